// ----- sv/edn_pkg.sv -----
// Package for the case-insensitive edit distance block.
// Holds item types, opcode codes, the cell-to-cell link type and the case fold.
// Used by edn_cell and edit_distance_nocase_unit; depends on nothing.
`default_nettype none

package edn_pkg;

    localparam int MAX_FIRST_DEF = 64;
    localparam int DIST_W        = 16;
    localparam int CHAR_W        = 8;
    localparam logic [DIST_W-1:0] SECOND_LIMIT = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_PROCESS = 2'd2,
        OP_FINISH  = 2'd3
    } t_op;

    typedef struct packed {
        t_op               opcode;
        logic [CHAR_W-1:0] char_byte;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out;

    // Wavefront token handed from one cell to the next.
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;    // folded second-string byte
        logic [DIST_W-1:0] up;    // new value of the cell on the left
        logic [DIST_W-1:0] diag;  // old value of the cell on the left
    } t_link;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/edn_cell.sv -----
// One cell of the edit distance row: holds one first-string byte and one
// column entry, and updates it as the wavefront token passes. Uses edn_pkg.
`default_nettype none

module edn_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic [edn_pkg::DIST_W-1:0] i_init,
    input  wire logic                       i_load,
    input  wire logic [edn_pkg::CHAR_W-1:0] i_char,
    input  wire edn_pkg::t_link             i_link,
    output edn_pkg::t_link                  o_link
);

    logic                       r_act;
    logic [edn_pkg::CHAR_W-1:0] r_char;
    logic [edn_pkg::DIST_W-1:0] r_dp;
    edn_pkg::t_link             r_link;

    logic [edn_pkg::DIST_W:0]   w_a;
    logic [edn_pkg::DIST_W:0]   w_b;
    logic [edn_pkg::DIST_W:0]   w_c;
    logic [edn_pkg::DIST_W:0]   w_m;
    logic [edn_pkg::DIST_W-1:0] n_dp;

    always_comb begin
        w_a = {1'b0, r_dp} + 17'd1;
        w_b = {1'b0, i_link.up} + 17'd1;
        w_c = {1'b0, i_link.diag} + {16'd0, (r_char != i_link.ch)};
        w_m = (w_a < w_b) ? w_a : w_b;
        w_m = (w_m < w_c) ? w_m : w_c;
        n_dp = w_m[edn_pkg::DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_act        <= 1'b0;
            r_dp         <= i_init;
            r_link.valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_act  <= 1'b1;
                r_char <= edn_pkg::fold_case(i_char);
            end
            if (i_link.valid && r_act) begin
                r_dp        <= n_dp;
                r_link      <= '{valid: 1'b1, ch: i_link.ch, up: n_dp, diag: r_dp};
            end else begin
                // Cells past the end of the first string pass the token on.
                r_link <= i_link;
            end
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

// ----- sv/edit_distance_nocase_unit.sv -----
// Top level of the case-insensitive edit distance block.
// Instantiates a row of edn_cell; uses edn_pkg for types and codes.
`default_nettype none

// Usage. Items enter on i_item when start is high and busy is low. A start
// opcode clears the block, exactly like reset. Append items load the first
// string, one byte per cell, into a row of MAX_FIRST cells; an append after
// the second string has begun is ignored. Process items run one second-string
// byte through the row: a token carrying the folded byte, the new value of
// the left neighbor and its old value moves one cell per cycle, and each
// loaded cell updates its column entry as the token passes. Cells beyond the
// first string forward the token unchanged, so it always reaches the end of
// the row, where its value is kept as the current distance.
// A process item holds busy high until its token has left the end of the cell
// row and its value is stored; every other item leaves busy low.
// A finish item puts one result on o_result with o_valid high for exactly one
// cycle, in the cycle after it is accepted; the state is left unchanged.
// Bytes beyond the first-string capacity, or a second string longer than
// 65535 bytes, are dropped and set the overflow flag of later results.
// Reset is synchronous and active low and leaves the block empty and idle.
// The receiver cannot stall: a result is valid for its single cycle only.

module edit_distance_nocase_unit #(
    parameter int MAX_FIRST = edn_pkg::MAX_FIRST_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire edn_pkg::t_in i_item,
    output logic              busy,
    output logic              o_valid,
    output edn_pkg::t_out     o_result
);

    localparam int FL_W  = $clog2(MAX_FIRST + 1);
    localparam int CNT_W = $clog2(MAX_FIRST + 2);

    logic [FL_W-1:0]            r_first_len;
    logic [edn_pkg::DIST_W-1:0] r_second_len;
    logic                       r_ovf;
    logic [edn_pkg::DIST_W-1:0] r_dist;
    logic [CNT_W-1:0]           r_cnt;
    edn_pkg::t_link             r_link0;
    logic                       r_out_valid;
    edn_pkg::t_out              r_out;

    logic                       w_acc;
    logic                       w_clear;
    logic                       w_append_ok;
    logic                       w_process_ok;
    logic [edn_pkg::DIST_W-1:0] w_row;

    edn_pkg::t_link             w_link [0:MAX_FIRST];
    logic [MAX_FIRST-1:0]       w_load;

    assign w_acc   = start && !busy;
    assign w_clear = w_acc && (i_item.opcode == edn_pkg::OP_START);
    assign w_append_ok = w_acc && (i_item.opcode == edn_pkg::OP_APPEND)
                      && (r_second_len == '0)
                      && (r_first_len < FL_W'(MAX_FIRST));
    assign w_process_ok = w_acc && (i_item.opcode == edn_pkg::OP_PROCESS)
                       && (r_second_len != edn_pkg::SECOND_LIMIT);
    assign w_row = r_second_len + 16'd1;

    assign busy = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_first_len   <= '0;
            r_second_len  <= '0;
            r_ovf         <= 1'b0;
            r_dist        <= '0;
            r_cnt         <= '0;
            r_link0.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid   <= 1'b0;
            r_link0.valid <= 1'b0;
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            // The token leaving the last cell carries the entry at first_length.
            if (w_link[MAX_FIRST].valid) begin
                r_dist <= w_link[MAX_FIRST].up;
            end
            if (w_acc) begin
                unique case (i_item.opcode)
                    edn_pkg::OP_APPEND: begin
                        if (w_append_ok) begin
                            r_first_len <= r_first_len + FL_W'(1);
                            r_dist      <= edn_pkg::DIST_W'(r_first_len) + 16'd1;
                        end else if (r_second_len == '0) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    edn_pkg::OP_PROCESS: begin
                        if (w_process_ok) begin
                            r_second_len <= w_row;
                            r_cnt        <= CNT_W'(MAX_FIRST + 1);
                            r_link0      <= '{valid: 1'b1,
                                              ch: edn_pkg::fold_case(i_item.char_byte),
                                              up: w_row, diag: r_second_len};
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    edn_pkg::OP_FINISH: begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{distance: r_dist, overflow: r_ovf};
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign w_link[0] = r_link0;

    for (genvar k = 0; k < MAX_FIRST; k++) begin : g_cell
        assign w_load[k] = w_append_ok && (r_first_len == FL_W'(k));

        edn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_init  (edn_pkg::DIST_W'(k + 1)),
            .i_load  (w_load[k]),
            .i_char  (i_item.char_byte),
            .i_link  (w_link[k]),
            .o_link  (w_link[k+1])
        );
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire
